>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> sv/itrd_pkg.sv
// Types, constants and helpers for the radix digit converter.
package itrd_pkg;

  localparam int unsigned MaxDigits = 16;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned CharW     = 7;
  localparam int unsigned RadixW    = 5;
  localparam int unsigned PtrW      = $clog2(MaxDigits);
  localparam int unsigned CntW      = $clog2(MaxDigits + 1);
  localparam int unsigned InValueW  = 16;

  localparam logic [RadixW-1:0] RadixMin = 5'd2;
  localparam logic [RadixW-1:0] RadixMax = 5'd16;

  localparam logic [CharW-1:0] DIGIT_TABLE [MaxDigits] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  typedef struct packed {
    logic done;
    logic quo_zero;
  } div_status_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic full;
  } stk_status_t;

  function automatic logic [RadixW-1:0] clamp_radix(input logic [RadixW-1:0] r);
    logic [RadixW-1:0] res;
    res = r;
    if (r < RadixMin) res = RadixMin;
    if (r > RadixMax) res = RadixMax;
    return res;
  endfunction

endpackage

>>> sv/itrd_divider.sv
// Restoring divider, one quotient bit per cycle, small divisor.
module itrd_divider #(
  parameter int unsigned W = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [W-1:0]              dividend_i,
  input  logic [itrd_pkg::RadixW-1:0] divisor_i,
  output logic [W-1:0]              quotient_o,
  output logic [itrd_pkg::DigitW-1:0] remainder_o,
  output itrd_pkg::div_status_t     status_o
);
  import itrd_pkg::*;

  localparam int unsigned CW = $clog2(W);

  logic                busy_q;
  logic                done_q;
  logic [CW-1:0]       cnt_q;
  logic [DigitW-1:0]   rem_q;
  logic [W-1:0]        quo_q;
  logic [RadixW-1:0]   div_q;

  logic [RadixW-1:0]   shifted;
  logic [RadixW-1:0]   diff;
  logic                ge;
  logic [DigitW-1:0]   rem_d;

  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    ge      = (shifted >= div_q);
    diff    = shifted - div_q;
    rem_d   = ge ? diff[DigitW-1:0] : shifted[DigitW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign quotient_o        = quo_q;
  assign remainder_o       = rem_q;
  assign status_o.done     = done_q;
  assign status_o.quo_zero = (quo_q == '0);

endmodule

>>> sv/itrd_digit_stack.sv
// Last-in first-out store that reverses the digit order.
module itrd_digit_stack (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [itrd_pkg::DigitW-1:0] push_digit_i,
  input  logic                        pop_i,
  output logic [itrd_pkg::DigitW-1:0] pop_digit_o,
  output itrd_pkg::stk_status_t       status_o
);
  import itrd_pkg::*;

  logic [DigitW-1:0] mem [MaxDigits];
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   cnt_d;
  logic [PtrW-1:0]   top_idx_d;
  logic [DigitW-1:0] pop_digit_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i) cnt_d = cnt_q - 1'b1;
    top_idx_d = cnt_d[PtrW-1:0] - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Top of stack kept registered; a push forwards the new digit.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[cnt_q[PtrW-1:0]] <= push_digit_i;
      pop_digit_q          <= push_digit_i;
    end else begin
      pop_digit_q          <= mem[top_idx_d];
    end
  end

  assign pop_digit_o     = pop_digit_q;
  assign status_o.empty  = (cnt_q == '0);
  assign status_o.last   = (cnt_q == CntW'(1));
  assign status_o.full   = (cnt_q == CntW'(MaxDigits));

endmodule

>>> sv/integer_to_radix_digits_unit.sv
// Top level of the unsigned integer to radix digit character converter.
//
// Input channel: value_i and radix_i, transfer when in_valid_i is high and
// in_stall_o is low. radix_i is clamped to 2..16; only the low
// min(VALUE_WIDTH, 16) bits of value_i are converted.
// Output channel: one transfer per digit, digit_char_o in ASCII '0'-'9' or
// 'A'-'F', most significant first, no leading zeros; last_digit_o marks the
// final digit. A zero value gives a single '0'.
// Each digit is worked out by the shared bit-serial divider, whose width is
// the converted width; the digits then leave the stack one at a time.
// The input is stalled from transfer until the last digit sits in the output
// register; that digit may wait there while the next item is taken.
// A stall on the output holds the output register and pauses the stack.
// Reset clears the sequencer, the digit count and the output valid.
`include "assert_macros.svh"
module integer_to_radix_digits_unit #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [itrd_pkg::InValueW-1:0] value_i,
  input  logic [itrd_pkg::RadixW-1:0]   radix_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [itrd_pkg::CharW-1:0]    digit_char_o,
  output logic                          last_digit_o
);
  import itrd_pkg::*;

  localparam int unsigned EW = (VALUE_WIDTH < InValueW) ? VALUE_WIDTH : InValueW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_e;

  state_e            state_q;
  logic              out_valid_q;
  logic [CharW-1:0]  digit_char_q;
  logic              last_digit_q;
  logic [RadixW-1:0] radix_q;

  logic              in_xfer;
  logic              out_free;
  logic              div_start;
  logic              push;
  logic              pop;
  logic [EW-1:0]     dividend;
  logic [RadixW-1:0] divisor;
  logic [EW-1:0]     div_quo;
  logic [DigitW-1:0] div_rem;
  logic [DigitW-1:0] pop_digit;
  div_status_t       div_st;
  stk_status_t       stk_st;

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    in_xfer    = in_valid_i && !in_stall_o;
    out_free   = !out_valid_q || !out_stall_i;
    push       = (state_q == S_DIV) && div_st.done;
    div_start  = in_xfer || (push && !div_st.quo_zero);
    pop        = (state_q == S_EMIT) && out_free;
    dividend   = (state_q == S_IDLE) ? value_i[EW-1:0] : div_quo;
    divisor    = in_xfer ? clamp_radix(radix_i) : radix_q;
  end

  itrd_divider #(
    .W(EW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (dividend),
    .divisor_i   (divisor),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .status_o    (div_st)
  );

  itrd_digit_stack u_stack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_digit_i (div_rem),
    .pop_i        (pop),
    .pop_digit_o  (pop_digit),
    .status_o     (stk_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      digit_char_q <= '0;
      last_digit_q <= 1'b0;
      radix_q      <= RadixMin;
    end else begin
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            radix_q <= divisor;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_st.done && div_st.quo_zero) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            digit_char_q <= DIGIT_TABLE[pop_digit];
            last_digit_q <= stk_st.last;
            if (stk_st.last) state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = digit_char_q;
  assign last_digit_o = last_digit_q;

  `ASSERT_NEVER(a_idle_stack_empty, clk_i, rst_ni, state_q == S_IDLE && !stk_st.empty, "digits left in stack while idle")
  `ASSERT_PROP(a_push_no_overflow, clk_i, rst_ni, push |-> !stk_st.full, "digit stack overflow")
  `ASSERT_PROP(a_accept_starts_div, clk_i, rst_ni, in_xfer |=> state_q == S_DIV, "transfer did not start division")
  `ASSERT_NEVER(a_done_outside_div, clk_i, rst_ni, div_st.done && state_q != S_DIV, "divider done outside division")

endmodule

>>> sim/integer_to_radix_digits_unit_tb.sv
// Testbench for integer_to_radix_digits_unit: directed and random conversions checked per digit.
`timescale 1ns / 100ps
module integer_to_radix_digits_unit_tb;
  import itrd_pkg::*;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned NumRandom  = 256;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned HoldCycles = 1500;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } digit_t;

  typedef struct {
    logic [InValueW-1:0] value;
    logic [RadixW-1:0]   radix;
    string               text;
  } conv_row_t;

  // Empty text: expectation comes from the digit predictor.
  conv_row_t conv_rows [24] = '{
    '{16'd0,     5'd10, "0"},
    '{16'd0,     5'd2,  "0"},
    '{16'd0,     5'd31, "0"},
    '{16'hFFFF,  5'd16, "FFFF"},
    '{16'hFFFF,  5'd2,  "1111111111111111"},
    '{16'hFFFF,  5'd10, "65535"},
    '{16'd1,     5'd2,  "1"},
    '{16'd5,     5'd0,  "101"},
    '{16'd5,     5'd1,  "101"},
    '{16'd255,   5'd17, "FF"},
    '{16'd255,   5'd31, "FF"},
    '{16'd15,    5'd16, "F"},
    '{16'd10,    5'd16, ""},
    '{16'd16,    5'd16, ""},
    '{16'd9,     5'd10, ""},
    '{16'h8000,  5'd2,  "1000000000000000"},
    '{16'hAAAA,  5'd16, ""},
    '{16'h1234,  5'd16, ""},
    '{16'd1000,  5'd8,  ""},
    '{16'd100,   5'd10, ""},
    '{16'hFFFF,  5'd3,  ""},
    '{16'd21845, 5'd4,  ""},
    '{16'd12345, 5'd7,  ""},
    '{16'd255,   5'd15, ""}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [InValueW-1:0] value_i = '0;
  logic [RadixW-1:0]   radix_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [CharW-1:0]    digit_char_o;
  logic                last_digit_o;

  digit_t      digits_due [$];
  string       exp_text = "";
  logic        idle_on = 1'b1;
  int unsigned digits_seen = 0;
  int unsigned hold_left = 0;
  logic        held = 1'b0;
  int unsigned errors = 0;

  integer_to_radix_digits_unit #(
    .VALUE_WIDTH(ValueWidth)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .radix_i     (radix_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .digit_char_o(digit_char_o),
    .last_digit_o(last_digit_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic queue_digits(input logic [InValueW-1:0] value, input logic [RadixW-1:0] radix);
    logic [31:0] rest;
    int unsigned base;
    logic [3:0]  rev [MaxDigits];
    int          n;
    digit_t      d;
    rest = value & ((ValueWidth >= InValueW) ? 32'hFFFF : (32'd1 << ValueWidth) - 1);
    base = (radix < 2) ? 2 : ((radix > 16) ? 16 : radix);
    n = 0;
    do begin
      rev[n] = 4'(rest % base);
      rest = rest / base;
      n++;
    end while (rest != 0 && n < MaxDigits);
    for (int k = n - 1; k >= 0; k--) begin
      d.ch = (rev[k] < 10) ? 7'h30 + 7'(rev[k]) : 7'h41 + 7'(rev[k]) - 7'd10;
      d.last = (k == 0);
      digits_due.push_back(d);
    end
  endtask

  task automatic send_item(input logic [InValueW-1:0] v, input logic [RadixW-1:0] r,
                           input string text);
    while (idle_on && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= v;
    radix_i <= r;
    exp_text <= text;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Scoreboard: expectations queued at input transfer, checked at output transfer.
  always @(posedge clk_i) begin : monitor
    digit_t want;
    digit_t typed;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (exp_text.len() != 0) begin
          for (int k = 0; k < exp_text.len(); k++) begin
            typed.ch = CharW'(exp_text[k]);
            typed.last = (k == exp_text.len() - 1);
            digits_due.push_back(typed);
          end
        end else begin
          queue_digits(value_i, radix_i);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        digits_seen <= digits_seen + 1;
        if (digits_due.size() == 0) begin
          $display("%0t: unexpected digit, expected none, got %h last %b",
                   $time, digit_char_o, last_digit_o);
          errors++;
        end else begin
          want = digits_due.pop_front();
          if (digit_char_o !== want.ch) begin
            $display("%0t: digit_char expected %h got %h", $time, want.ch, digit_char_o);
            errors++;
          end
          if (last_digit_o !== want.last) begin
            $display("%0t: last_digit expected %b got %b", $time, want.last, last_digit_o);
            errors++;
          end
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off while the sender keeps offering.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!held && digits_seen >= 150) begin
      out_stall_i <= 1'b1;
      hold_left <= HoldCycles;
      held <= 1'b1;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < 11);
    end
  end

  initial begin
    #(10_000_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [InValueW-1:0] v;
    logic [RadixW-1:0]   r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (conv_rows[i]) send_item(conv_rows[i].value, conv_rows[i].radix, conv_rows[i].text);

    for (int i = 0; i < NumRandom; i++) begin
      idle_on <= !(i >= 120 && i < 180);
      case ($urandom_range(3))
        0: v = 16'($urandom);
        1: v = 16'($urandom_range(255));
        2: v = (16'd1 << $urandom_range(15)) - 16'($urandom_range(1));
        default: v = 16'hFFFF - 16'($urandom_range(15));
      endcase
      r = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 2));
      send_item(v, r, "");
    end
    in_valid_i <= 1'b0;

    while (digits_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && digits_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
